// ===== src/assert_macros.svh =====
// Assertion macros for the serial master RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Check on every clock edge, off while reset is asserted.
`define ASSERT_RST(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check on every clock edge, reset included.
`define ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_RST(name, clk, rst_n, prop, msg)
`define ASSERT_ALWAYS(name, clk, prop, msg)
`endif

`endif

// ===== src/twrtc_pkg.sv =====
// Types and constants for the three-wire serial RTC master.
// No dependencies; used by every module of the block.
package twrtc_pkg;

  localparam int unsigned ByteBits   = 8;
  localparam int unsigned WordBits   = 2 * ByteBits;
  localparam int unsigned QueueDepth = 2;

  // input mode codes
  localparam logic [1:0] MODE_WRITE = 2'd0;
  localparam logic [1:0] MODE_READ  = 2'd1;
  localparam logic [1:0] MODE_TICK  = 2'd2;

  typedef struct packed {
    logic [1:0]          mode;
    logic [ByteBits-1:0] command_byte;
    logic [6:0]          write_value;
    logic                line_in;
  } in_t;

  typedef struct packed {
    logic                chip_enable;
    logic                clock_pulse;
    logic                line_out;
    logic                line_drive;
    logic                done_res;
    logic [ByteBits-1:0] read_value;
  } out_t;

  typedef enum logic [1:0] {
    OP_START_WR,
    OP_START_RD,
    OP_TICK
  } op_e;

  // classified item as it travels from front to back
  typedef struct packed {
    op_e                 op;
    logic [WordBits-1:0] word;
    logic                line_in;
  } op_t;

endpackage

// ===== src/twrtc_front.sv =====
// Front end: accepts input items, drops unknown modes, builds the send word.
// Depends on twrtc_pkg.
module twrtc_front (
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  twrtc_pkg::in_t   in_data_i,
  output logic             push_o,
  output twrtc_pkg::op_t   push_data_o,
  input  logic             full_i
);

  // Saturate at 99, then split into tens and ones; tens by reciprocal 205/2048.
  function automatic logic [7:0] to_bcd(input logic [6:0] dec);
    logic [6:0]  sat;
    logic [14:0] prod;
    logic [3:0]  tens;
    logic [6:0]  ones;
    sat  = (dec > 7'd99) ? 7'd99 : dec;
    prod = 15'(sat) * 15'd205;
    tens = prod[14:11];
    ones = sat - 7'(tens) * 7'd10;
    return {tens, ones[3:0]};
  endfunction

  logic accept;
  logic known;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && !full_i;

  always_comb begin
    known               = 1'b1;
    push_data_o.op      = twrtc_pkg::OP_TICK;
    push_data_o.word    = '0;
    push_data_o.line_in = in_data_i.line_in;
    unique case (in_data_i.mode)
      twrtc_pkg::MODE_WRITE: begin
        push_data_o.op   = twrtc_pkg::OP_START_WR;
        push_data_o.word = {to_bcd(in_data_i.write_value), in_data_i.command_byte};
      end
      twrtc_pkg::MODE_READ: begin
        push_data_o.op   = twrtc_pkg::OP_START_RD;
        push_data_o.word = {{twrtc_pkg::ByteBits{1'b0}},
                            in_data_i.command_byte + twrtc_pkg::ByteBits'(1)};
      end
      twrtc_pkg::MODE_TICK: begin
        push_data_o.op = twrtc_pkg::OP_TICK;
      end
      default: begin
        known = 1'b0;
      end
    endcase
  end

  // drop unknown modes here so they never reach the back end
  assign push_o = accept && known;

endmodule

// ===== src/twrtc_fifo.sv =====
// Short queue of classified items between front and back end.
// Depends on twrtc_pkg.
module twrtc_fifo #(
  parameter int unsigned Depth = twrtc_pkg::QueueDepth
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  twrtc_pkg::op_t push_data_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output twrtc_pkg::op_t pop_data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  twrtc_pkg::op_t  mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_pop;

  assign full_o     = (count_q == CntW'(Depth));
  assign valid_o    = (count_q != '0);
  assign pop_data_o = mem_q[rd_ptr_q];
  assign do_pop     = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push_i && !do_pop) begin
      count_d = count_q + CntW'(1);
    end else if (!push_i && do_pop) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== src/twrtc_back.sv =====
// Back end: runs the access bit by bit and holds the result register.
// Depends on twrtc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module twrtc_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  twrtc_pkg::op_t   op_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output twrtc_pkg::out_t  out_data_o
);

  localparam int unsigned ByteBits = twrtc_pkg::ByteBits;
  localparam int unsigned WordBits = twrtc_pkg::WordBits;
  localparam int unsigned CntW     = $clog2(WordBits + 1);
  localparam int unsigned PosW     = $clog2(ByteBits);

  // high nibble times ten plus low nibble; invalid digits pass through
  function automatic logic [7:0] from_bcd(input logic [7:0] bcd);
    logic [7:0] hi;
    hi = {4'b0, bcd[7:4]};
    return (hi << 3) + (hi << 1) + {4'b0, bcd[3:0]};
  endfunction

  logic [WordBits-1:0] send_q, send_d;
  logic [CntW-1:0]     count_q, count_d;
  logic                busy_q, busy_d;
  logic                is_read_q, is_read_d;
  logic [ByteBits-1:0] recv_q, recv_d;
  logic                out_valid_q, out_valid_d;
  twrtc_pkg::out_t     out_q, out_d;

  logic                take;
  logic [CntW-1:0]     count_inc;
  logic                receiving;
  logic                done;

  // advance whenever the result register is free or being emptied
  assign take  = !out_valid_q || out_ready_i;
  assign pop_o = take && valid_i;

  assign count_inc = count_q + CntW'(1);
  assign receiving = is_read_q && (count_q >= CntW'(ByteBits));
  assign done      = (count_inc >= CntW'(WordBits));

  always_comb begin
    send_d      = send_q;
    count_d     = count_q;
    busy_d      = busy_q;
    is_read_d   = is_read_q;
    recv_d      = recv_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    if (pop_o) begin
      unique case (op_i.op) inside
        twrtc_pkg::OP_START_WR,
        twrtc_pkg::OP_START_RD: begin
          // a start while an access runs is dropped
          if (!busy_q) begin
            busy_d    = 1'b1;
            count_d   = '0;
            recv_d    = '0;
            is_read_d = (op_i.op == twrtc_pkg::OP_START_RD);
            send_d    = op_i.word;
          end
        end
        twrtc_pkg::OP_TICK: begin
          if (busy_q) begin
            out_d             = '0;
            out_d.clock_pulse = 1'b1;
            if (receiving) begin
              out_d.line_drive = 1'b0;
              if (op_i.line_in) begin
                recv_d[count_q[PosW-1:0]] = 1'b1;
              end
            end else begin
              out_d.line_drive = 1'b1;
              out_d.line_out   = send_q[0];
              send_d           = send_q >> 1;
            end
            count_d           = count_inc;
            out_d.done_res    = done;
            out_d.chip_enable = !done;
            if (done) begin
              if (is_read_q) begin
                out_d.read_value = from_bcd(recv_d);
              end
              busy_d  = 1'b0;
              count_d = '0;
            end
            out_valid_d = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      send_q      <= '0;
      count_q     <= '0;
      busy_q      <= 1'b0;
      is_read_q   <= 1'b0;
      recv_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      send_q      <= send_d;
      count_q     <= count_d;
      busy_q      <= busy_d;
      is_read_q   <= is_read_d;
      recv_q      <= recv_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `ASSERT_ALWAYS(a_idle_count_zero, clk_i, !busy_q |-> (count_q == '0), "count runs while idle")
  `ASSERT_RST(a_count_in_range, clk_i, rst_ni, count_q < CntW'(WordBits), "count past last tick")
  `ASSERT_RST(a_done_drops_ce, clk_i, rst_ni, out_valid_q |-> (out_q.done_res != out_q.chip_enable), "chip enable not dropped with done")
  `ASSERT_RST(a_value_only_on_done, clk_i, rst_ni, (out_valid_q && !out_q.done_res) |-> (out_q.read_value == '0), "read value outside final tick")

endmodule

// ===== src/three_wire_rtc_serial_master.sv =====
// Top level of the three-wire serial RTC master: front end, queue, back end.
// Depends on twrtc_pkg, twrtc_front, twrtc_fifo and twrtc_back.
//
//   port group   direction  handshake                  payload
//   in_*         input      in_valid_i / in_ready_o    twrtc_pkg::in_t
//   out_*        output     out_valid_o / out_ready_i  twrtc_pkg::out_t
//
// One item per cycle sustained while out_ready_i is high: the front end classifies
// in the accept cycle, the back end handles one queued item per cycle and registers
// its result. A bit tick accepted from in_* is written into the queue, popped into
// the result register, and handed over on out_* from there.
// Reset clears the queue, the access state and the result valid flag.
// A stalled output holds the back end; the queue then fills and in_ready_o drops.
module three_wire_rtc_serial_master #(
  parameter int unsigned QueueDepth = twrtc_pkg::QueueDepth
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  twrtc_pkg::in_t  in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output twrtc_pkg::out_t out_data_o
);

  logic           push;
  twrtc_pkg::op_t push_data;
  logic           full;
  logic           pop;
  logic           q_valid;
  twrtc_pkg::op_t q_data;

  twrtc_front u_front (
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .push_o      (push),
    .push_data_o (push_data),
    .full_i      (full)
  );

  twrtc_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .valid_o     (q_valid),
    .pop_data_o  (q_data)
  );

  twrtc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (q_valid),
    .op_i        (q_data),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
